[rtl/core/seconds_counter_to_calendar_unit_macros.svh]
// Assertion macros for the seconds-to-calendar unit.
// Clocked on clk and disabled while arst_n is low; used at the end of the top level.
`ifndef SECONDS_COUNTER_TO_CALENDAR_UNIT_MACROS_SVH
`define SECONDS_COUNTER_TO_CALENDAR_UNIT_MACROS_SVH

// same-cycle implication
`define SCTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/sctc_pkg.sv]
// Shared types, constants and helper functions of the seconds-to-calendar unit.
// No dependencies; used by the controller, the datapath and the top level.
package sctc_pkg;

	localparam int BASE_YEAR = 1970;
	localparam int BASE_PY   = BASE_YEAR - 1;

	localparam logic [31:0] RESET_COUNT   = 32'd1489972112;
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN  = 17'd60;

	// base-year residues for the leap test and weekday of Jan 1
	localparam logic [1:0] BASE_M4   = 2'(BASE_YEAR % 4);
	localparam logic [6:0] BASE_M100 = 7'(BASE_YEAR % 100);
	localparam logic [8:0] BASE_M400 = 9'(BASE_YEAR % 400);
	localparam logic [2:0] BASE_WDAY =
		3'((BASE_PY + BASE_PY / 4 - BASE_PY / 100 + BASE_PY / 400 + 1) % 7);

	// each division: quotient step, then back-multiply step
	localparam int DAY_STEPS  = 2;
	localparam int HOUR_STEPS = 2;
	localparam int MIN_STEPS  = 2;
	localparam int STEP_W     = $clog2(DAY_STEPS);

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DAY,
		CMD_YEAR,
		CMD_MON,
		CMD_HOUR,
		CMD_MIN,
		CMD_PUBLISH
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [STEP_W-1:0] step;
	} ctl_t;

	typedef struct packed {
		logic year_done;
		logic mon_done;
	} sts_t;

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
		logic [4:0] len;
		case (mon)
			4'd1: len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// x mod 7 for x < 42
	function automatic logic [2:0] mod7(input logic [5:0] x);
		logic [5:0] r;
		r = x;
		for (int i = 0; i < 5; i++) begin
			if (r >= 6'd7) begin
				r = r - 6'd7;
			end
		end
		return r[2:0];
	endfunction

endpackage

[rtl/core/sctc_ifs.sv]
// Valid/ready channel interfaces of the seconds-to-calendar unit.
// sctc_req_if carries request beats, sctc_rsp_if carries calendar beats.
interface sctc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] new_timestamp;

	modport source(output valid, req_type, new_timestamp, input ready);
	modport sink(input valid, req_type, new_timestamp, output ready);
endinterface

interface sctc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] timestamp;
	logic [7:0]  year_offset;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [2:0]  weekday;

	modport source(output valid, timestamp, year_offset, month, day_of_month, hour,
		minute, second, weekday, input ready);
	modport sink(input valid, timestamp, year_offset, month, day_of_month, hour,
		minute, second, weekday, output ready);
endinterface

[rtl/core/seconds_counter_to_calendar_unit.sv]
// Seconds counter with calendar conversion: top level.
// Depends on sctc_pkg, sctc_ifs, sctc_ctrl, sctc_dpath and the macros header.
//
// req: one beat either ticks the 32-bit seconds counter (req_type 0) or
// loads new_timestamp (req_type 1). rsp: one beat per request with the
// counter value and the calendar form of counter + tz_offset (years since
// the base year, month, day, hour, minute, second, weekday 0 = Sunday).
// cfg_we/cfg_wdata write the signed 17-bit time-zone offset; write it only
// while no request is in flight.
// rsp.valid rises once the request has passed day division, the year walk
// (one year per cycle, up to 136 years), the month walk (up to 11 months),
// hour and minute division and the publish step. The year walk can take by
// far the longest; day, hour and minute division each take a quotient step
// and a back-multiply step. One request is worked at a time; req.ready is
// high only while idle, so a new request is taken only after the last is published.
// The result sits in an output register, so a new request is taken while
// a finished beat waits on rsp.ready; a stalled receiver holds the next
// result back until the register frees.
// Reset: counter returns to 1489972112 (2017-03-20 01:08:32), offset to 0,
// no result pending.
`include "seconds_counter_to_calendar_unit_macros.svh"

module seconds_counter_to_calendar_unit import sctc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic signed [16:0] cfg_wdata,
	sctc_req_if.sink           req,
	sctc_rsp_if.source         rsp
);

	ctl_t ctl;
	sts_t sts;

	sctc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	sctc_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_type      (req.req_type),
		.new_timestamp (req.new_timestamp),
		.ctl           (ctl),
		.sts           (sts),
		.timestamp     (rsp.timestamp),
		.year_offset   (rsp.year_offset),
		.month         (rsp.month),
		.day_of_month  (rsp.day_of_month),
		.hour          (rsp.hour),
		.minute        (rsp.minute),
		.second        (rsp.second),
		.weekday       (rsp.weekday)
	);

	`SCTC_ASSERT_NEXT(a_req_starts_div, req.valid && req.ready, ctl.cmd == CMD_DAY, "request beat did not start day division")
	`SCTC_ASSERT_NOW(a_walks_done, ctl.cmd == CMD_HOUR, sts.year_done && sts.mon_done, "hour division began before year/month walk finished")
	`SCTC_ASSERT_NOW(a_rsp_date_range, rsp.valid, rsp.month >= 4'd1 && rsp.month <= 4'd12 && rsp.day_of_month != 5'd0, "result month or day out of range")

endmodule

[rtl/core/sctc_ctrl.sv]
// Controller of the seconds-to-calendar unit: sequences load, day division,
// year and month walks, hour and minute division and result publish. Uses sctc_pkg.
module sctc_ctrl import sctc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output ctl_t ctl,
	input  sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DAY,
		S_YEAR,
		S_MON,
		S_HOUR,
		S_MIN,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              rsp_valid_q;
	logic              slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		ctl.step = step_q;
		case (state_q)
			S_IDLE: ctl.cmd = req_valid ? CMD_LOAD : CMD_NONE;
			S_DAY:  ctl.cmd = CMD_DAY;
			S_YEAR: ctl.cmd = CMD_YEAR;
			S_MON:  ctl.cmd = CMD_MON;
			S_HOUR: ctl.cmd = CMD_HOUR;
			S_MIN:  ctl.cmd = CMD_MIN;
			S_DONE: ctl.cmd = slot_free ? CMD_PUBLISH : CMD_NONE;
			default: ctl.cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (req_valid) begin
						state_q <= S_DAY;
					end
				end
				S_DAY: begin
					if (step_q == STEP_W'(DAY_STEPS - 1)) begin
						state_q <= S_YEAR;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_YEAR: begin
					if (sts.year_done) begin
						state_q <= S_MON;
					end
				end
				S_MON: begin
					if (sts.mon_done) begin
						state_q <= S_HOUR;
						step_q  <= STEP_W'(HOUR_STEPS - 1);
					end
				end
				S_HOUR: begin
					if (step_q == '0) begin
						state_q <= S_MIN;
						step_q  <= STEP_W'(MIN_STEPS - 1);
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				S_MIN: begin
					if (step_q == '0) begin
						state_q <= S_DONE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/sctc_dpath.sv]
// Datapath of the seconds-to-calendar unit: seconds counter, offset register,
// reciprocal-multiply dividers, year/month walk and result register. Uses sctc_pkg.
module sctc_dpath import sctc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic signed [16:0] cfg_wdata,
	input  logic              req_type,
	input  logic [31:0]       new_timestamp,
	input  ctl_t              ctl,
	output sts_t              sts,
	output logic [31:0]       timestamp,
	output logic [7:0]        year_offset,
	output logic [3:0]        month,
	output logic [4:0]        day_of_month,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	output logic [5:0]        second,
	output logic [2:0]        weekday
);

	// 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2; rounded-up reciprocals
	// are exact over the shifted operand ranges
	localparam logic [25:0] DAY_RECIP  = 26'd50903317; // ceil(2^35 / 675)
	localparam logic [13:0] HOUR_RECIP = 14'd9321;     // ceil(2^21 / 225)
	localparam logic [10:0] MIN_RECIP  = 11'd1093;     // ceil(2^14 / 15)

	logic signed [16:0] tz_q;
	logic [31:0] count_q;
	logic [31:0] num_q;
	logic [16:0] rem_q;
	logic [15:0] days_q;
	logic [7:0]  yoff_q;
	logic [1:0]  m4_q;
	logic [6:0]  m100_q;
	logic [8:0]  m400_q;
	logic [2:0]  wday_q;
	logic [3:0]  mon_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;

	logic [31:0] ts_out_q;
	logic [7:0]  yoff_out_q;
	logic [3:0]  mon_out_q;
	logic [4:0]  dom_out_q;
	logic [4:0]  hour_out_q;
	logic [5:0]  min_out_q;
	logic [5:0]  sec_out_q;
	logic [2:0]  wday_out_q;

	logic [31:0] next_count;
	logic [31:0] local_secs;
	logic        leap;
	logic [8:0]  ylen;
	logic        year_more;
	logic [4:0]  mlen;
	logic        mon_more;
	logic [50:0] day_prod;
	logic [16:0] day_rem;
	logic [25:0] hour_prod;
	logic [16:0] hour_rem;
	logic [19:0] min_prod;
	logic [16:0] min_rem;

	assign next_count = req_type ? new_timestamp : count_q + 32'd1;
	assign local_secs = next_count + {{15{tz_q[16]}}, tz_q};

	assign leap      = (m4_q == 2'd0 && m100_q != 7'd0) || (m400_q == 9'd0);
	assign ylen      = leap ? 9'd366 : 9'd365;
	assign year_more = days_q >= {7'd0, ylen};
	assign mlen      = month_len(leap, mon_q);
	assign mon_more  = (mon_q < 4'd11) && (days_q >= {11'd0, mlen});

	assign day_prod  = {26'd0, num_q[31:7]} * {25'd0, DAY_RECIP};
	// remainder fits 17 bits, so only the low bits of the back-product matter
	assign day_rem   = num_q[16:0] - ({1'b0, days_q} * SECS_PER_DAY);
	assign hour_prod = {13'd0, rem_q[16:4]} * {12'd0, HOUR_RECIP};
	assign hour_rem  = rem_q - ({12'd0, hour_q} * SECS_PER_HOUR);
	assign min_prod  = {10'd0, rem_q[11:2]} * {9'd0, MIN_RECIP};
	assign min_rem   = rem_q - ({11'd0, min_q} * SECS_PER_MIN);

	assign sts.year_done = !year_more;
	assign sts.mon_done  = !mon_more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q    <= '0;
			count_q <= RESET_COUNT;
		end else begin
			if (cfg_we) begin
				tz_q <= cfg_wdata;
			end
			if (ctl.cmd == CMD_LOAD) begin
				count_q <= next_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LOAD: begin
				num_q  <= local_secs;
				rem_q  <= '0;
				days_q <= '0;
				yoff_q <= '0;
				m4_q   <= BASE_M4;
				m100_q <= BASE_M100;
				m400_q <= BASE_M400;
				wday_q <= BASE_WDAY;
				mon_q  <= '0;
				hour_q <= '0;
				min_q  <= '0;
			end
			CMD_DAY: begin
				if (ctl.step == '0) begin
					days_q <= day_prod[50:35];
				end else begin
					rem_q <= day_rem;
				end
			end
			CMD_YEAR: begin
				if (year_more) begin
					days_q <= days_q - {7'd0, ylen};
					yoff_q <= yoff_q + 8'd1;
					m4_q   <= m4_q + 2'd1;
					m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
					m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
					// 365 mod 7 = 1, 366 mod 7 = 2
					wday_q <= mod7({3'd0, wday_q} + (leap ? 6'd2 : 6'd1));
				end
			end
			CMD_MON: begin
				if (mon_more) begin
					days_q <= days_q - {11'd0, mlen};
					mon_q  <= mon_q + 4'd1;
					wday_q <= mod7({3'd0, wday_q} + {1'b0, mlen} - 6'd28);
				end
			end
			// step counts down: quotient first, then back-multiply
			CMD_HOUR: begin
				if (ctl.step != '0) begin
					hour_q <= hour_prod[25:21];
				end else begin
					rem_q <= hour_rem;
				end
			end
			CMD_MIN: begin
				if (ctl.step != '0) begin
					min_q <= min_prod[19:14];
				end else begin
					rem_q <= min_rem;
				end
			end
			CMD_PUBLISH: begin
				ts_out_q   <= count_q;
				yoff_out_q <= yoff_q;
				mon_out_q  <= mon_q + 4'd1;
				dom_out_q  <= days_q[4:0] + 5'd1;
				hour_out_q <= hour_q;
				min_out_q  <= min_q;
				sec_out_q  <= rem_q[5:0];
				wday_out_q <= mod7({3'd0, wday_q} + {1'b0, days_q[4:0]});
			end
			default: begin
			end
		endcase
	end

	assign timestamp    = ts_out_q;
	assign year_offset  = yoff_out_q;
	assign month        = mon_out_q;
	assign day_of_month = dom_out_q;
	assign hour         = hour_out_q;
	assign minute       = min_out_q;
	assign second       = sec_out_q;
	assign weekday      = wday_out_q;

endmodule
